// ===== sv/mie_pkg.sv =====
// shared types, constants and helpers for the immediate/jump execute core
`default_nettype none

package mie_pkg;

    // data memory geometry; the depth is a power of two so the word index is a mask
    localparam int MEM_WORDS   = 1024;
    localparam int MEM_IDX_W   = $clog2(MEM_WORDS);
    localparam int PORT_IDX_W  = 10;

    // register file geometry
    localparam int REG_COUNT   = 32;
    localparam int REG_IDX_W   = 5;
    localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;
    localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd0;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // instruction kinds
    localparam logic [1:0] KIND_IMM = 2'd0;
    localparam logic [1:0] KIND_JAL = 2'd1;
    localparam logic [1:0] KIND_JMP = 2'd2;

    // major opcodes
    localparam logic [5:0] OPC_BLTZ = 6'd1;
    localparam logic [5:0] OPC_BEQ  = 6'd4;
    localparam logic [5:0] OPC_BNE  = 6'd5;
    localparam logic [5:0] OPC_ADDI = 6'd8;
    localparam logic [5:0] OPC_SLTI = 6'd10;
    localparam logic [5:0] OPC_ANDI = 6'd12;
    localparam logic [5:0] OPC_ORI  = 6'd13;
    localparam logic [5:0] OPC_XORI = 6'd14;
    localparam logic [5:0] OPC_LUI  = 6'd15;
    localparam logic [5:0] OPC_LW   = 6'd35;
    localparam logic [5:0] OPC_SW   = 6'd43;

    // operation class produced by the front decoder
    typedef enum logic [3:0] {
        CLS_ADDI,
        CLS_SLTI,
        CLS_ANDI,
        CLS_ORI,
        CLS_XORI,
        CLS_LUI,
        CLS_LW,
        CLS_SW,
        CLS_BLTZ,
        CLS_BEQ,
        CLS_BNE,
        CLS_JAL,
        CLS_JMP,
        CLS_BAD
    } op_class_t;

    // decoded instruction as it travels through the queue
    typedef struct packed {
        op_class_t              cls;
        logic [REG_IDX_W-1:0]   src;
        logic [REG_IDX_W-1:0]   tgt;
        logic [15:0]            imm;
        logic [27:0]            target;
    } op_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    // one retired result
    typedef struct packed {
        logic [31:0]            next_pc;
        logic                   branch_taken;
        logic                   reg_written;
        logic [REG_IDX_W-1:0]   dest_index;
        logic [31:0]            dest_value;
        logic                   mem_written;
        logic [PORT_IDX_W-1:0]  mem_word_index;
        logic [31:0]            mem_value;
        logic                   bad_opcode;
    } res_t;

    // word index widened or trimmed to the reported width
    function automatic logic [PORT_IDX_W-1:0] port_idx(input logic [MEM_IDX_W-1:0] idx);
        logic [MEM_IDX_W+PORT_IDX_W-1:0] wide;
        wide = {{PORT_IDX_W{1'b0}}, idx};
        return wide[PORT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/mips_itype_and_jump_execute_core.sv =====
// Immediate-format and jump instruction execute core, top level.
// Input channel (in_valid/in_ready): one decoded instruction per transaction,
// fields kind, opcode, src_index, tgt_index, immediate and jump_target.
// Output channel (out_valid/out_ready): one result transaction per instruction
// with the new pc, branch and register write flags, the memory access and
// the bad opcode flag.
// The front decodes each transaction into an operation class and pushes it
// into a two-entry queue; the back reads both source registers, executes,
// writes back and retires into an output register.
// The back end takes one instruction at a time: it reads the register file,
// then executes and writes back, with the data memory read in between for
// a load.
// Reset clears the pc, the register file (all registers read as zero) and
// the queue; data memory contents are undefined until stored.
// When the receiver stalls the result stays in the output register, the
// back holds the next instruction and the queue then fills, dropping in_ready.
`default_nettype none

module mips_itype_and_jump_execute_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     kind,
    input  wire logic [5:0]                     opcode,
    input  wire logic [4:0]                     src_index,
    input  wire logic [4:0]                     tgt_index,
    input  wire logic signed [15:0]             immediate,
    input  wire logic [27:0]                    jump_target,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [31:0]                         next_pc,
    output logic                                branch_taken,
    output logic                                reg_written,
    output logic [mie_pkg::REG_IDX_W-1:0]       dest_index,
    output logic [31:0]                         dest_value,
    output logic                                mem_written,
    output logic [mie_pkg::PORT_IDX_W-1:0]      mem_word_index,
    output logic [31:0]                         mem_value,
    output logic                                bad_opcode
);
    import mie_pkg::*;

    queue_status_t  q_status;
    logic           q_push;
    logic           q_pop;
    op_t            push_op;
    op_t            head_op;
    res_t           res;

    // front end
    mie_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .opcode      (opcode),
        .src_index   (src_index),
        .tgt_index   (tgt_index),
        .immediate   (immediate),
        .jump_target (jump_target),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    // decoupling queue
    mie_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // back end
    mie_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    // result fields
    assign next_pc        = res.next_pc;
    assign branch_taken   = res.branch_taken;
    assign reg_written    = res.reg_written;
    assign dest_index     = res.dest_index;
    assign dest_value     = res.dest_value;
    assign mem_written    = res.mem_written;
    assign mem_word_index = res.mem_word_index;
    assign mem_value      = res.mem_value;
    assign bad_opcode     = res.bad_opcode;

endmodule

`default_nettype wire

// ===== sv/mie_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module mie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/mie_front.sv =====
// front end: accepts instructions and classifies them into operation classes
`default_nettype none

module mie_front (
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             kind,
    input  wire logic [5:0]             opcode,
    input  wire logic [4:0]             src_index,
    input  wire logic [4:0]             tgt_index,
    input  wire logic [15:0]            immediate,
    input  wire logic [27:0]            jump_target,
    input  wire mie_pkg::queue_status_t q_status,
    output logic                        q_push,
    output mie_pkg::op_t                q_op
);
    import mie_pkg::*;

    op_class_t cls;

    // opcode and kind decoder
    always_comb
    begin
        cls = CLS_BAD;
        unique case (kind)
            KIND_IMM:
            begin
                unique case (opcode)
                    OPC_BLTZ: cls = CLS_BLTZ;
                    OPC_BEQ:  cls = CLS_BEQ;
                    OPC_BNE:  cls = CLS_BNE;
                    OPC_ADDI: cls = CLS_ADDI;
                    OPC_SLTI: cls = CLS_SLTI;
                    OPC_ANDI: cls = CLS_ANDI;
                    OPC_ORI:  cls = CLS_ORI;
                    OPC_XORI: cls = CLS_XORI;
                    OPC_LUI:  cls = CLS_LUI;
                    OPC_LW:   cls = CLS_LW;
                    OPC_SW:   cls = CLS_SW;
                    default:  cls = CLS_BAD;
                endcase
            end
            KIND_JAL: cls = CLS_JAL;
            KIND_JMP: cls = CLS_JMP;
            default:  cls = CLS_BAD;
        endcase
    end

    // a transaction goes straight into the queue
    assign in_ready  = !q_status.full;
    assign q_push    = in_valid && in_ready;
    assign q_op.cls    = cls;
    assign q_op.src    = src_index;
    assign q_op.tgt    = tgt_index;
    assign q_op.imm    = immediate;
    assign q_op.target = jump_target;

endmodule

`default_nettype wire

// ===== sv/mie_queue.sv =====
// short fifo of decoded instructions between front and back
`default_nettype none

module mie_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mie_pkg::op_t           push_op,
    input  wire logic                   pop,
    output mie_pkg::op_t                head_op,
    output mie_pkg::queue_status_t      status
);
    import mie_pkg::*;

    op_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_op      = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // never pop an empty queue or push a full one without a pop; a lone push raises the count
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> status.valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!status.full || pop))
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== sv/mie_back.sv =====
// back end: register file, data memory and pc, executes one instruction at a time
`default_nettype none

module mie_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mie_pkg::queue_status_t q_status,
    input  wire mie_pkg::op_t           q_op,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output mie_pkg::res_t               out_res
);
    import mie_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    op_t                    op_reg;
    logic [31:0]            pc_reg;
    logic [31:0]            pc_next;
    logic [REG_COUNT-1:0]   rf_valid_reg;
    logic [MEM_IDX_W-1:0]   idx_reg;
    res_t                   res_reg;
    logic                   out_valid_reg;

    logic [REG_IDX_W-1:0]   rf_raddr_a;
    logic [REG_IDX_W-1:0]   rf_raddr_b;
    logic [31:0]            rf_rdata_a;
    logic [31:0]            rf_rdata_b;
    logic [31:0]            a;
    logic [31:0]            b;
    logic                   rf_we;
    logic [REG_IDX_W-1:0]   rf_waddr;
    logic [31:0]            rf_wdata;

    logic [31:0]            imm_sext;
    logic [31:0]            imm_zext;
    logic [31:0]            word_addr;
    logic [MEM_IDX_W-1:0]   idx_now;
    logic [MEM_IDX_W-1:0]   dm_addr;
    logic                   dm_we;
    logic [31:0]            dm_rdata;

    logic [31:0]            pc_plus4;
    logic [31:0]            br_target;
    logic [31:0]            jmp_target;

    logic                   out_free;
    logic                   done;
    logic                   wr_req;
    logic [REG_IDX_W-1:0]   wr_idx;
    logic [31:0]            wr_val;
    res_t                   res;

    // register file, two copies so both sources are read each cycle
    mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_addr (rf_raddr_a),
        .rd_data (rf_rdata_a)
    );

    mie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_addr (rf_raddr_b),
        .rd_data (rf_rdata_b)
    );

    // data memory
    mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .clk     (clk),
        .wr_en   (dm_we),
        .wr_addr (dm_addr),
        .wr_data (b),
        .rd_addr (dm_addr),
        .rd_data (dm_rdata)
    );

    // source reads: queue head while idle, held instruction otherwise
    assign rf_raddr_a = (state_reg == ST_IDLE) ? q_op.src : op_reg.src;
    assign rf_raddr_b = (state_reg == ST_IDLE) ? q_op.tgt : op_reg.tgt;
    assign a = rf_valid_reg[op_reg.src] ? rf_rdata_a : 32'd0;
    assign b = rf_valid_reg[op_reg.tgt] ? rf_rdata_b : 32'd0;

    // operand and address arithmetic
    assign imm_sext   = {{16{op_reg.imm[15]}}, op_reg.imm};
    assign imm_zext   = {16'd0, op_reg.imm};
    assign word_addr  = a + imm_sext;
    assign idx_now    = word_addr[MEM_IDX_W+1:2];
    assign dm_addr    = (state_reg == ST_EXEC) ? idx_now : idx_reg;
    assign pc_plus4   = pc_reg + 32'd4;
    assign br_target  = pc_reg + {imm_sext[29:0], 2'b00};
    assign jmp_target = {pc_reg[31:28], op_reg.target};

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_status.valid;

    // execute and retire
    always_comb
    begin
        res        = '0;
        pc_next    = pc_plus4;
        wr_req     = 1'b0;
        wr_idx     = op_reg.tgt;
        wr_val     = 32'd0;
        dm_we      = 1'b0;
        done       = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg.cls)
                    CLS_ADDI:
                    begin
                        wr_req = 1'b1;
                        wr_val = a + imm_sext;
                    end
                    CLS_SLTI:
                    begin
                        wr_req = 1'b1;
                        wr_val = {31'd0, $signed(a) < $signed(imm_sext)};
                    end
                    CLS_ANDI:
                    begin
                        wr_req = 1'b1;
                        wr_val = a & imm_zext;
                    end
                    CLS_ORI:
                    begin
                        wr_req = 1'b1;
                        wr_val = a | imm_zext;
                    end
                    CLS_XORI:
                    begin
                        wr_req = 1'b1;
                        wr_val = a ^ imm_zext;
                    end
                    CLS_LUI:
                    begin
                        wr_req = 1'b1;
                        wr_val = {op_reg.imm, 16'd0};
                    end
                    CLS_SW:
                    begin
                        res.mem_written    = 1'b1;
                        res.mem_word_index = port_idx(idx_now);
                        res.mem_value      = b;
                    end
                    CLS_BLTZ:
                    begin
                        if (a[31])
                        begin
                            res.branch_taken = 1'b1;
                            pc_next          = br_target;
                        end
                    end
                    CLS_BEQ:
                    begin
                        if (a == b)
                        begin
                            res.branch_taken = 1'b1;
                            pc_next          = br_target;
                        end
                    end
                    CLS_BNE:
                    begin
                        if (a != b)
                        begin
                            res.branch_taken = 1'b1;
                            pc_next          = br_target;
                        end
                    end
                    CLS_JAL:
                    begin
                        wr_req  = 1'b1;
                        wr_idx  = LINK_REG;
                        wr_val  = pc_reg + 32'd8;
                        pc_next = jmp_target;
                    end
                    CLS_JMP:
                    begin
                        pc_next = jmp_target;
                    end
                    CLS_LW:
                    begin
                        // result waits for the memory read
                    end
                    default:
                    begin
                        res.bad_opcode = 1'b1;
                    end
                endcase
                if (op_reg.cls == CLS_LW)
                begin
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    done       = 1'b1;
                    dm_we      = (op_reg.cls == CLS_SW);
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                wr_req             = 1'b1;
                wr_val             = dm_rdata;
                res.mem_word_index = port_idx(idx_reg);
                res.mem_value      = dm_rdata;
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register zero discards writes
        if (wr_req && (wr_idx != ZERO_REG))
        begin
            res.reg_written = 1'b1;
            res.dest_index  = wr_idx;
            res.dest_value  = wr_val;
        end
        res.next_pc = pc_next;
    end

    assign rf_we    = done && res.reg_written;
    assign rf_waddr = res.dest_index;
    assign rf_wdata = res.dest_value;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 32'd0;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                pc_reg        <= pc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        if (state_reg == ST_EXEC)
        begin
            idx_reg <= idx_now;
        end
        if (done)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // register zero is never written
    assert property (@(posedge clk) disable iff (!rst_n) !rf_valid_reg[0])
        else $error("register zero marked written");
    // memory is written only by a retiring store
    assert property (@(posedge clk) disable iff (!rst_n)
        dm_we |-> (state_reg == ST_EXEC) && (op_reg.cls == CLS_SW) && done)
        else $error("data memory written outside a store");
    // a retired instruction always shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n) done |=> out_valid_reg)
        else $error("retired transaction not presented");
    // pc only moves when an instruction retires
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(pc_reg))
        else $error("pc changed without a retirement");

endmodule

`default_nettype wire

// ===== verif/mie_exec_checker.sv =====
// channel monitor, instruction predictor and result comparison for the execute core
`timescale 1ns / 1ps

module mie_exec_checker
    import mie_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              kind,
    input  logic [5:0]              opcode,
    input  logic [4:0]              src_index,
    input  logic [4:0]              tgt_index,
    input  logic [15:0]             immediate,
    input  logic [27:0]             jump_target,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [31:0]             next_pc,
    input  logic                    branch_taken,
    input  logic                    reg_written,
    input  logic [REG_IDX_W-1:0]    dest_index,
    input  logic [31:0]             dest_value,
    input  logic                    mem_written,
    input  logic [PORT_IDX_W-1:0]   mem_word_index,
    input  logic [31:0]             mem_value,
    input  logic                    bad_opcode,
    output int                      mismatch_count,
    output int                      outstanding
);

    // architectural state as the predictor sees it
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] pc;

    res_t expected_results[$];
    int   mismatches = 0;
    int   queued_results = 0;
    int   results_seen = 0;

    assign mismatch_count = mismatches;
    assign outstanding    = queued_results;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result transaction %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want_v));
    endtask

    // execute one instruction on the shadow state and return its effects
    function automatic res_t execute_instr(input logic [1:0] k, input logic [5:0] op,
                                           input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [15:0] imm16,
                                           input logic [27:0] target);
        res_t                 r;
        logic [31:0]          a;
        logic [31:0]          b;
        logic [31:0]          imm32;
        logic [31:0]          next;
        logic [31:0]          addr;
        logic [MEM_IDX_W-1:0] widx;
        logic                 wr_en;
        logic [4:0]           wr_idx;
        logic [31:0]          wr_val;

        r      = '0;
        a      = gpr[rs];
        b      = gpr[rt];
        imm32  = {{16{imm16[15]}}, imm16};
        next   = pc + 32'd4;
        addr   = a + imm32;
        widx   = MEM_IDX_W'((addr >> 2) % MEM_WORDS);
        wr_en  = 1'b0;
        wr_idx = rt;
        wr_val = '0;

        if (k == KIND_JAL || k == KIND_JMP)
        begin
            next = {pc[31:28], target};
            if (k == KIND_JAL)
            begin
                wr_en  = 1'b1;
                wr_idx = LINK_REG;
                wr_val = pc + 32'd8;
            end
        end
        else if (k != KIND_IMM)
            r.bad_opcode = 1'b1;
        else
        begin
            case (op)
                OPC_BLTZ: r.branch_taken = a[31];
                OPC_BEQ:  r.branch_taken = (a == b);
                OPC_BNE:  r.branch_taken = (a != b);
                OPC_ADDI:
                begin
                    wr_en  = 1'b1;
                    wr_val = a + imm32;
                end
                OPC_SLTI:
                begin
                    wr_en  = 1'b1;
                    wr_val = {31'd0, $signed(a) < $signed(imm32)};
                end
                OPC_ANDI:
                begin
                    wr_en  = 1'b1;
                    wr_val = a & {16'd0, imm16};
                end
                OPC_ORI:
                begin
                    wr_en  = 1'b1;
                    wr_val = a | {16'd0, imm16};
                end
                OPC_XORI:
                begin
                    wr_en  = 1'b1;
                    wr_val = a ^ {16'd0, imm16};
                end
                OPC_LUI:
                begin
                    wr_en  = 1'b1;
                    wr_val = {imm16, 16'd0};
                end
                OPC_LW:
                begin
                    wr_en            = 1'b1;
                    wr_val           = dmem[widx];
                    r.mem_word_index = port_idx(widx);
                    r.mem_value      = dmem[widx];
                end
                OPC_SW:
                begin
                    dmem[widx]       = b;
                    r.mem_written    = 1'b1;
                    r.mem_word_index = port_idx(widx);
                    r.mem_value      = b;
                end
                default: r.bad_opcode = 1'b1;
            endcase
        end

        if (r.branch_taken)
            next = pc + (imm32 << 2);

        // writes to register zero are dropped and not reported
        if (wr_en && wr_idx != ZERO_REG)
        begin
            gpr[wr_idx]   = wr_val;
            r.reg_written = 1'b1;
            r.dest_index  = wr_idx;
            r.dest_value  = wr_val;
        end

        pc        = next;
        r.next_pc = next;
        return r;
    endfunction

    // watch both channels: compare retired results, predict accepted instructions
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = '0;
            pc = '0;
            expected_results.delete();
            queued_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with no instruction outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("next_pc", next_pc, want.next_pc);
                    check_field("branch_taken", 32'(branch_taken), 32'(want.branch_taken));
                    check_field("reg_written", 32'(reg_written), 32'(want.reg_written));
                    check_field("dest_index", 32'(dest_index), 32'(want.dest_index));
                    check_field("dest_value", dest_value, want.dest_value);
                    check_field("mem_written", 32'(mem_written), 32'(want.mem_written));
                    check_field("mem_word_index", 32'(mem_word_index),
                                32'(want.mem_word_index));
                    check_field("mem_value", mem_value, want.mem_value);
                    check_field("bad_opcode", 32'(bad_opcode), 32'(want.bad_opcode));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(execute_instr(kind, opcode, src_index, tgt_index,
                                                         immediate, jump_target));
            queued_results <= expected_results.size();
        end
    end

endmodule

// ===== verif/mips_itype_and_jump_execute_core_test.sv =====
// testbench top: clock, reset, instruction stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module mips_itype_and_jump_execute_core_test;
    import mie_pkg::*;

    localparam int         STALL_LIMIT  = 1000;
    localparam int         RANDOM_ITEMS = 1100;
    localparam int         DRAIN_CYCLES = 12;
    localparam logic [5:0] OPC_UNUSED   = 6'd63;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic [1:0]             kind        = '0;
    logic [5:0]             opcode      = '0;
    logic [4:0]             src_index   = '0;
    logic [4:0]             tgt_index   = '0;
    logic [15:0]            immediate   = '0;
    logic [27:0]            jump_target = '0;
    logic                   out_ready   = 1'b0;

    logic                   in_ready;
    logic                   out_valid;
    logic [31:0]            next_pc;
    logic                   branch_taken;
    logic                   reg_written;
    logic [REG_IDX_W-1:0]   dest_index;
    logic [31:0]            dest_value;
    logic                   mem_written;
    logic [PORT_IDX_W-1:0]  mem_word_index;
    logic [31:0]            mem_value;
    logic                   bad_opcode;

    int mismatch_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int issued        = 0;
    int idle_run      = 0;

    // words stored through register zero, safe to load back
    bit                   word_written [MEM_WORDS];
    logic [MEM_IDX_W-1:0] written_words[$];

    logic [5:0] common_ops [9] = '{OPC_ADDI, OPC_SLTI, OPC_ANDI, OPC_ORI, OPC_XORI,
                                   OPC_LUI, OPC_BLTZ, OPC_BEQ, OPC_BNE};
    logic [5:0] branch_ops [3] = '{OPC_BLTZ, OPC_BEQ, OPC_BNE};

    mips_itype_and_jump_execute_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .opcode         (opcode),
        .src_index      (src_index),
        .tgt_index      (tgt_index),
        .immediate      (immediate),
        .jump_target    (jump_target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_pc        (next_pc),
        .branch_taken   (branch_taken),
        .reg_written    (reg_written),
        .dest_index     (dest_index),
        .dest_value     (dest_value),
        .mem_written    (mem_written),
        .mem_word_index (mem_word_index),
        .mem_value      (mem_value),
        .bad_opcode     (bad_opcode)
    );

    mie_exec_checker result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .opcode         (opcode),
        .src_index      (src_index),
        .tgt_index      (tgt_index),
        .immediate      (immediate),
        .jump_target    (jump_target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_pc        (next_pc),
        .branch_taken   (branch_taken),
        .reg_written    (reg_written),
        .dest_index     (dest_index),
        .dest_value     (dest_value),
        .mem_written    (mem_written),
        .mem_word_index (mem_word_index),
        .mem_value      (mem_value),
        .bad_opcode     (bad_opcode),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles without any transaction
    initial
    begin
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // immediate biased toward the field extremes
    function automatic logic [15:0] rand_imm();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [27:0] rand_target();
        case ($urandom_range(9))
            0:       return 28'h0000000;
            1:       return 28'hfffffff;
            default: return 28'($urandom);
        endcase
    endfunction

    // one instruction transaction, with random idle cycles ahead of it
    task automatic issue_instr(input logic [1:0] k, input logic [5:0] op,
                               input logic [4:0] rs, input logic [4:0] rt,
                               input logic [15:0] imm, input logic [27:0] target);
        logic [MEM_IDX_W-1:0] widx;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        opcode      <= op;
        src_index   <= rs;
        tgt_index   <= rt;
        immediate   <= imm;
        jump_target <= target;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        issued++;
        // a store based on register zero hits a word known from the immediate alone
        if (k == KIND_IMM && op == OPC_SW && rs == ZERO_REG)
        begin
            widx = imm[MEM_IDX_W+1:2];
            if (!word_written[widx])
            begin
                word_written[widx] = 1'b1;
                written_words.push_back(widx);
            end
        end
    endtask

    // hold off the sender until every result has retired
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // extremes, every operation, register zero, bad opcode and bad kind
    task automatic run_directed();
        issue_instr(KIND_IMM, OPC_ADDI, 5'd0, 5'd1, 16'hffff, rand_target());
        issue_instr(KIND_IMM, OPC_ADDI, 5'd0, 5'd2, 16'h7fff, rand_target());
        issue_instr(KIND_IMM, OPC_ADDI, 5'd1, 5'd3, 16'h8000, rand_target());
        issue_instr(KIND_IMM, OPC_SLTI, 5'd1, 5'd4, 16'h0000, rand_target());
        issue_instr(KIND_IMM, OPC_SLTI, 5'd2, 5'd5, 16'h8000, rand_target());
        issue_instr(KIND_IMM, OPC_ANDI, 5'd1, 5'd6, 16'hffff, rand_target());
        issue_instr(KIND_IMM, OPC_ORI, 5'd2, 5'd7, 16'h8000, rand_target());
        issue_instr(KIND_IMM, OPC_XORI, 5'd1, 5'd8, 16'h5555, rand_target());
        issue_instr(KIND_IMM, OPC_LUI, 5'd0, 5'd9, 16'h8000, rand_target());
        // writes to register zero are discarded
        issue_instr(KIND_IMM, OPC_LUI, 5'd0, 5'd0, 16'h1234, rand_target());
        issue_instr(KIND_IMM, OPC_ADDI, 5'd1, 5'd0, 16'h0005, rand_target());
        // top and bottom words of memory, load into register zero too
        issue_instr(KIND_IMM, OPC_SW, 5'd0, 5'd1, 16'hfffc, rand_target());
        issue_instr(KIND_IMM, OPC_LW, 5'd0, 5'd10, 16'hfffc, rand_target());
        issue_instr(KIND_IMM, OPC_LW, 5'd0, 5'd0, 16'hfffc, rand_target());
        issue_instr(KIND_IMM, OPC_SW, 5'd0, 5'd2, 16'h0000, rand_target());
        issue_instr(KIND_IMM, OPC_LW, 5'd0, 5'd11, 16'h0000, rand_target());
        // branches taken and not taken
        issue_instr(KIND_IMM, OPC_BLTZ, 5'd9, 5'd0, 16'h0003, rand_target());
        issue_instr(KIND_IMM, OPC_BLTZ, 5'd2, 5'd0, 16'hffff, rand_target());
        issue_instr(KIND_IMM, OPC_BEQ, 5'd1, 5'd10, 16'h8000, rand_target());
        issue_instr(KIND_IMM, OPC_BEQ, 5'd1, 5'd2, 16'h0005, rand_target());
        issue_instr(KIND_IMM, OPC_BNE, 5'd1, 5'd2, 16'h7fff, rand_target());
        issue_instr(KIND_IMM, OPC_BNE, 5'd0, 5'd0, 16'h0001, rand_target());
        // unknown opcode and unknown kind
        issue_instr(KIND_IMM, OPC_UNUSED, 5'd31, 5'd31, rand_imm(), rand_target());
        issue_instr(KIND_UNUSED, OPC_ADDI, 5'd1, 5'd12, rand_imm(), rand_target());
        // jumps ignore opcode and immediate
        issue_instr(KIND_JAL, 6'($urandom), 5'd0, 5'd0, rand_imm(), 28'hffffffc);
        issue_instr(KIND_IMM, OPC_SW, 5'd31, 5'd6, 16'h7fff, rand_target());
        issue_instr(KIND_JMP, 6'($urandom), 5'd3, 5'd4, rand_imm(), 28'h0000000);
    endtask

    // random mix: single operations, store/load pairs, build-then-branch, noise
    task automatic run_random(input int count);
        int          stop_at;
        int          pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rt2;
        logic [5:0]  op;
        logic [15:0] imm;
        stop_at = issued + count;
        while (issued < stop_at)
        begin
            pick = $urandom_range(99);
            rs   = 5'($urandom);
            rt   = 5'($urandom);
            imm  = rand_imm();
            if (pick < 40)
            begin
                op = common_ops[$urandom_range(8)];
                if ((op == OPC_BEQ || op == OPC_BNE) && $urandom_range(9) < 3)
                    rt = rs;
                issue_instr(KIND_IMM, op, rs, rt, imm, rand_target());
            end
            else if (pick < 52 || (pick < 62 && written_words.size() == 0))
                issue_instr(KIND_IMM, OPC_SW, ZERO_REG, rt, imm, rand_target());
            else if (pick < 62)
            begin
                imm[MEM_IDX_W+1:2] = written_words[$urandom_range(written_words.size() - 1)];
                issue_instr(KIND_IMM, OPC_LW, ZERO_REG, rt, imm, rand_target());
            end
            else if (pick < 74)
            begin
                // load right back from the word just stored through any base
                rt2 = 5'($urandom);
                issue_instr(KIND_IMM, OPC_SW, rs, rt, imm, rand_target());
                issue_instr(KIND_IMM, OPC_LW, rs, rt2, imm, rand_target());
            end
            else if (pick < 84)
            begin
                // build a full word from two halves, then branch on it
                if (rs == ZERO_REG)
                    rs = 5'd1;
                issue_instr(KIND_IMM, OPC_LUI, ZERO_REG, rs, imm, rand_target());
                issue_instr(KIND_IMM, OPC_ORI, rs, rs, rand_imm(), rand_target());
                op = branch_ops[$urandom_range(2)];
                issue_instr(KIND_IMM, op, rs, rt, rand_imm(), rand_target());
            end
            else if (pick < 92)
                issue_instr($urandom_range(1) ? KIND_JAL : KIND_JMP, 6'($urandom),
                            rs, rt, imm, rand_target());
            else if (pick < 97)
            begin
                // any opcode; loads stay off words never stored
                op = 6'($urandom);
                if (op == OPC_LW)
                    op = OPC_UNUSED;
                issue_instr(KIND_IMM, op, rs, rt, imm, rand_target());
            end
            else
                issue_instr(KIND_UNUSED, 6'($urandom), rs, rt, imm, rand_target());
        end
    endtask

    // reset, directed part, three idling phases, verdict
    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 59;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_results();
        run_random(RANDOM_ITEMS / 3);
        wait_for_results();

        send_idle_pct = 59;
        recv_idle_pct = 23;
        run_random(RANDOM_ITEMS / 3);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
